>>> hdl/keyframe_track_evaluator_core_assert.svh
// Assertion macros shared by the keyframe track evaluator RTL.
`ifndef KEYFRAME_TRACK_EVALUATOR_CORE_ASSERT_SVH
`define KEYFRAME_TRACK_EVALUATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define KTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KTE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define KTE_ASSERT(lbl, prop, msg)
`define KTE_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> hdl/kte_pkg.sv
// Types, codes and helpers for the keyframe track evaluator.
`timescale 1ns / 1ps
package kte_pkg;

  localparam logic [2:0] OP_INSERT     = 3'd0;
  localparam logic [2:0] OP_INSERT_DEF = 3'd1;
  localparam logic [2:0] OP_SET_TIME   = 3'd2;
  localparam logic [2:0] OP_REMOVE     = 3'd3;
  localparam logic [2:0] OP_EVAL       = 3'd4;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_EMPTY     = 2'd3;

  localparam logic [2:0] KIND_REAL    = 3'd0;
  localparam logic [2:0] KIND_INTEGER = 3'd1;
  localparam logic [2:0] KIND_BOOL    = 3'd2;
  localparam logic [2:0] KIND_VEC3    = 3'd3;
  localparam logic [2:0] KIND_VEC2    = 3'd4;
  localparam logic [2:0] KIND_COLOUR  = 3'd5;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_STEP   = 2'd1;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [16:0] T_ONE   = 17'h1_0000;

  typedef logic [3:0][31:0] lanes_t;

  typedef struct packed {
    logic [31:0] key_tm;
    lanes_t      lanes;
    logic [1:0]  mode;
    logic [2:0]  kind;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_DEF_RD, S_DEF, S_SCAN_RD, S_SCAN, S_SHIFT_RD, S_SHIFT,
    S_PUT, S_SET_RD, S_SET, S_REM_RD, S_REM, S_EV0_RD, S_EV0, S_EVL_RD, S_EVL,
    S_MID_RD, S_MID, S_LO_RD, S_LO, S_HI_RD, S_HI, S_DIV, S_MUL, S_SUM
  } fsm_t;

  // lanes left live by a value kind; the rest read as zero
  function automatic lanes_t mask_lanes(input logic [2:0] kind, input lanes_t v);
    lanes_t r;
    r = '0;
    case (kind)
      KIND_REAL, KIND_INTEGER, KIND_BOOL: r[0] = v[0];
      KIND_VEC3: begin
        r[0] = v[0]; r[1] = v[1]; r[2] = v[2];
      end
      KIND_VEC2: begin
        r[0] = v[0]; r[1] = v[1];
      end
      KIND_COLOUR: r = v;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/keyframe_track_evaluator_core.sv
// Top level of the keyframe track evaluator: key table, sequencer and lane merge.
`timescale 1ns / 1ps
//
// Channel   Handshake          Payload
// --------  -----------------  ---------------------------------------------------
// request   start, busy        operation, key_time, key_index, interp_mode,
//                              value_kind, lane_zero .. lane_three
// result    done (one cycle)   status, result_kind, out_lane_zero .. out_lane_three,
//                              key_count
//
// A request is taken when start is high and busy low; busy stays high until the
// cycle the result strobe appears. One request is in flight at a time.
// Insert scans the entries, then shifts the later ones up one at a time, as set by the
// single read port of the key table. Remove moves each later entry down one at a time.
// Evaluate does a binary search over the keys, then may wait on the serial divider.
// rst is synchronous and clears the sequencer and the key count; the table itself
// is not cleared, only entries below the count are ever read.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "keyframe_track_evaluator_core_assert.svh"
module keyframe_track_evaluator_core
  import kte_pkg::*;
#(
  parameter int MAX_KEYS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [31:0] key_time,
  input  logic [5:0]  key_index,
  input  logic [1:0]  interp_mode,
  input  logic [2:0]  value_kind,
  input  logic [31:0] lane_zero,
  input  logic [31:0] lane_one,
  input  logic [31:0] lane_two,
  input  logic [31:0] lane_three,
  output logic        done,
  output logic [1:0]  status,
  output logic [2:0]  result_kind,
  output logic [31:0] out_lane_zero,
  output logic [31:0] out_lane_one,
  output logic [31:0] out_lane_two,
  output logic [31:0] out_lane_three,
  output logic [6:0]  key_count
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int IW = (CW > 6) ? CW : 6;

  // key table, one read and one write port
  entry_t mem [MAX_KEYS];
  entry_t rd;
  logic   mem_we;
  logic [AW-1:0] mem_wa;
  entry_t mem_wd;

  fsm_t state, state_next;
  logic [AW-1:0] ptr, ptr_next, pos, pos_next, lo, lo_next, hi, hi_next;
  logic [CW-1:0] count, count_next;
  logic [2:0]  op, op_next;
  logic [31:0] nt, nt_next;
  logic [5:0]  nidx, nidx_next;
  logic [1:0]  nmode, nmode_next;
  logic [2:0]  nkind, nkind_next;
  lanes_t      nlanes, nlanes_next;
  entry_t      ea, ea_next;
  lanes_t      eb, eb_next;
  logic [16:0] tfrac, tfrac_next;

  logic        fin;
  logic [1:0]  fin_status;
  logic [2:0]  fin_kind;
  lanes_t      fin_lanes;
  lanes_t      status_lanes;
  lanes_t      lane_y;
  logic [2:0]  kind_q;

  logic        div_start, div_done, lane_load;
  logic [15:0] div_quo;
  logic signed [32:0] num_c, den_c;
  logic [AW:0] mid_sum;
  logic [AW-1:0] lo_c, hi_c;
  logic        idx_ok, full;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd <= mem[ptr];
  end

  assign idx_ok = IW'(nidx) < IW'(count);
  assign full   = count == CW'(MAX_KEYS);
  assign num_c  = $signed({nt[31], nt}) - $signed({ea.key_tm[31], ea.key_tm});
  assign den_c  = $signed({rd.key_tm[31], rd.key_tm})
                - $signed({ea.key_tm[31], ea.key_tm});

  always_comb begin
    state_next  = state;
    ptr_next    = ptr;
    pos_next    = pos;
    lo_next     = lo;
    hi_next     = hi;
    count_next  = count;
    op_next     = op;
    nt_next     = nt;
    nidx_next   = nidx;
    nmode_next  = nmode;
    nkind_next  = nkind;
    nlanes_next = nlanes;
    ea_next     = ea;
    eb_next     = eb;
    tfrac_next  = tfrac;
    mem_we      = 1'b0;
    mem_wa      = ptr;
    mem_wd      = rd;
    fin         = 1'b0;
    fin_status  = STAT_OK;
    fin_kind    = KIND_REAL;
    fin_lanes   = '0;
    div_start   = 1'b0;
    lane_load   = 1'b0;
    lo_c        = lo;
    hi_c        = hi;
    mid_sum     = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          op_next     = operation;
          nt_next     = key_time;
          nidx_next   = key_index;
          nmode_next  = interp_mode;
          nkind_next  = value_kind;
          nlanes_next = {lane_three, lane_two, lane_one, lane_zero};
          if (value_kind == KIND_BOOL) begin
            nlanes_next[0] = {31'd0, lane_zero != 32'd0};
          end
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op)
          OP_INSERT, OP_INSERT_DEF: begin
            if (op == OP_INSERT_DEF) begin
              nmode_next  = MODE_LINEAR;
              nkind_next  = KIND_REAL;
              nlanes_next = '0;
            end
            if (full) begin
              fin = 1'b1; fin_status = STAT_FULL; state_next = S_IDLE;
            end else if (count == '0) begin
              pos_next = '0; state_next = S_PUT;
            end else begin
              ptr_next   = '0;
              state_next = (op == OP_INSERT_DEF) ? S_DEF_RD : S_SCAN_RD;
            end
          end
          OP_SET_TIME: begin
            if (idx_ok) begin
              ptr_next = AW'(nidx); state_next = S_SET_RD;
            end else begin
              fin = 1'b1; fin_status = STAT_BAD_INDEX; state_next = S_IDLE;
            end
          end
          OP_REMOVE: begin
            if (!idx_ok) begin
              fin = 1'b1; fin_status = STAT_BAD_INDEX; state_next = S_IDLE;
            end else if (IW'(nidx) + IW'(1) == IW'(count)) begin
              count_next = count - 1'b1; fin = 1'b1; state_next = S_IDLE;
            end else begin
              ptr_next = AW'(nidx) + 1'b1; state_next = S_REM_RD;
            end
          end
          OP_EVAL: begin
            if (count == '0) begin
              fin = 1'b1; fin_status = STAT_EMPTY; state_next = S_IDLE;
            end else begin
              ptr_next = '0; state_next = S_EV0_RD;
            end
          end
          default: begin
            fin = 1'b1; state_next = S_IDLE;
          end
        endcase
      end
      S_DEF_RD: state_next = S_DEF;
      S_DEF: begin
        // default key follows entry 0's kind; unknown kinds fall back to real
        if (rd.kind inside {[KIND_REAL:KIND_COLOUR]}) begin
          nkind_next = rd.kind;
        end
        if (rd.kind == KIND_COLOUR) begin
          nlanes_next = {ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16};
        end
        state_next = S_SCAN_RD;
      end
      S_SCAN_RD: state_next = S_SCAN;
      S_SCAN: begin
        if ($signed(nt) < $signed(rd.key_tm)) begin
          pos_next = ptr; ptr_next = AW'(count - 1'b1); state_next = S_SHIFT_RD;
        end else if (ptr == AW'(count - 1'b1)) begin
          pos_next = AW'(count); state_next = S_PUT;
        end else begin
          ptr_next = ptr + 1'b1; state_next = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_next = S_SHIFT;
      S_SHIFT: begin
        mem_we = 1'b1; mem_wa = ptr + 1'b1; mem_wd = rd;
        if (ptr == pos) begin
          state_next = S_PUT;
        end else begin
          ptr_next = ptr - 1'b1; state_next = S_SHIFT_RD;
        end
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_wa = pos;
        mem_wd = '{key_tm: nt, lanes: nlanes, mode: nmode, kind: nkind};
        count_next = count + 1'b1;
        fin = 1'b1; state_next = S_IDLE;
      end
      S_SET_RD: state_next = S_SET;
      S_SET: begin
        mem_we = 1'b1; mem_wd = rd; mem_wd.key_tm = nt;
        fin = 1'b1; state_next = S_IDLE;
      end
      S_REM_RD: state_next = S_REM;
      S_REM: begin
        mem_we = 1'b1; mem_wa = ptr - 1'b1; mem_wd = rd;
        if (ptr == AW'(count - 1'b1)) begin
          count_next = count - 1'b1; fin = 1'b1; state_next = S_IDLE;
        end else begin
          ptr_next = ptr + 1'b1; state_next = S_REM_RD;
        end
      end
      S_EV0_RD: state_next = S_EV0;
      S_EV0: begin
        if (count == CW'(1) || $signed(nt) <= $signed(rd.key_tm)) begin
          fin = 1'b1; fin_kind = rd.kind; fin_lanes = mask_lanes(rd.kind, rd.lanes);
          state_next = S_IDLE;
        end else begin
          ptr_next = AW'(count - 1'b1); state_next = S_EVL_RD;
        end
      end
      S_EVL_RD: state_next = S_EVL;
      S_MID_RD: state_next = S_MID;
      S_EVL, S_MID: begin
        if (state == S_EVL) begin
          lo_c = '0; hi_c = ptr;
        end else if ($signed(rd.key_tm) <= $signed(nt)) begin
          lo_c = ptr;
        end else begin
          hi_c = ptr;
        end
        lo_next = lo_c;
        hi_next = hi_c;
        mid_sum = {1'b0, lo_c} + {1'b0, hi_c};
        if (state == S_EVL && $signed(nt) >= $signed(rd.key_tm)) begin
          fin = 1'b1; fin_kind = rd.kind; fin_lanes = mask_lanes(rd.kind, rd.lanes);
          state_next = S_IDLE;
        end else if ({1'b0, lo_c} + 1'b1 < {1'b0, hi_c}) begin
          ptr_next = mid_sum[AW:1]; state_next = S_MID_RD;
        end else begin
          ptr_next = lo_c; state_next = S_LO_RD;
        end
      end
      S_LO_RD: state_next = S_LO;
      S_LO: begin
        ea_next = rd; ptr_next = hi; state_next = S_HI_RD;
      end
      S_HI_RD: state_next = S_HI;
      S_HI: begin
        eb_next = rd.lanes;
        if (ea.mode == MODE_STEP || !(ea.kind inside {KIND_REAL, KIND_VEC3, KIND_VEC2,
                                                      KIND_COLOUR})) begin
          fin = 1'b1; fin_kind = ea.kind; fin_lanes = mask_lanes(ea.kind, ea.lanes);
          state_next = S_IDLE;
        end else if (num_c <= 0 || den_c < 0) begin
          tfrac_next = '0; state_next = S_MUL;
        end else if (den_c == 0 || num_c >= den_c) begin
          tfrac_next = T_ONE; state_next = S_MUL;
        end else begin
          div_start = 1'b1; state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          tfrac_next = {1'b0, div_quo}; state_next = S_MUL;
        end
      end
      S_MUL: begin
        lane_load = 1'b1; state_next = S_SUM;
      end
      S_SUM: begin
        fin = 1'b1; fin_kind = ea.kind; fin_lanes = mask_lanes(ea.kind, lane_y);
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    pos    <= pos_next;
    lo     <= lo_next;
    hi     <= hi_next;
    op     <= op_next;
    nt     <= nt_next;
    nidx   <= nidx_next;
    nmode  <= nmode_next;
    nkind  <= nkind_next;
    nlanes <= nlanes_next;
    ea     <= ea_next;
    eb     <= eb_next;
    tfrac  <= tfrac_next;
    if (fin) begin
      status       <= fin_status;
      kind_q       <= fin_kind;
      status_lanes <= fin_lanes;
    end
  end

  // both times are in range here, so num and den are positive 32-bit values
  kte_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_c[31:0]),
    .den   (den_c[31:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  // four lanes side by side; the merge above masks them by kind
  for (genvar g = 0; g < 4; g++) begin : g_lane
    kte_lane u_lane (
      .clk  (clk),
      .load (lane_load),
      .a    (ea.lanes[g]),
      .b    (eb[g]),
      .t    (tfrac),
      .y    (lane_y[g])
    );
  end

  assign busy           = state != S_IDLE;
  assign result_kind    = kind_q;
  assign out_lane_zero  = status_lanes[0];
  assign out_lane_one   = status_lanes[1];
  assign out_lane_two   = status_lanes[2];
  assign out_lane_three = status_lanes[3];
  assign key_count      = 7'(count);

  `KTE_ASSERT(a_done_from_busy, done |-> $past(busy), "result strobe without a request")
  `KTE_ASSERT(a_accept_busy, (start && !busy) |=> busy, "request taken but not busy")
  `KTE_ASSERT_NEVER(a_count_max, count > CW'(MAX_KEYS), "key count beyond table size")

endmodule

>>> hdl/kte_lane.sv
// One interpolation lane: a + floor((b - a) * t / 65536).
`timescale 1ns / 1ps
module kte_lane
  import kte_pkg::*;
(
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [16:0] t,
  output logic [31:0] y
);

  logic signed [32:0] diff;
  logic signed [50:0] prod;
  logic signed [50:0] sum;

  assign diff = $signed({b[31], b}) - $signed({a[31], a});

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= diff * $signed({1'b0, t});
    end
  end

  // arithmetic shift is the floor
  assign sum = $signed({{19{a[31]}}, a}) + (prod >>> 16);
  assign y   = sum[31:0];

endmodule

>>> hdl/kte_div.sv
// Serial restoring divider for the 16-bit interpolation fraction.
`timescale 1ns / 1ps
module kte_div
  import kte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [15:0] quo
);

  logic [32:0] rem;
  logic [31:0] dsr;
  logic [4:0]  cnt;
  logic        run;
  logic [32:0] rem2;

  // num < den, so the remainder stays below 2*den
  assign rem2 = {rem[31:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= {1'b0, num};
        dsr <= den;
        cnt <= 5'd16;
        run <= 1'b1;
      end else if (run) begin
        if (rem2 >= {1'b0, dsr}) begin
          rem <= rem2 - {1'b0, dsr};
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= rem2;
          quo <= {quo[14:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> tb/keyframe_track_evaluator_core_tb.sv
// Self-checking testbench for the keyframe track evaluator core.
`timescale 1ns / 1ps
module keyframe_track_evaluator_core_tb;
  import kte_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int STALL_LIMIT = 20000;

  // Op codes 5..7, kinds 6 and 7 and modes 2 and 3 fall outside the package set; named here.
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;
  localparam logic [1:0] MODE_CUBIC  = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] tm;
    logic [5:0]  idx;
    logic [1:0]  mode;
    logic [2:0]  kind;
    lanes_t      lanes;
  } track_req_t;

  typedef struct {
    logic [1:0] status;
    logic [2:0] kind;
    lanes_t     lanes;
    logic [6:0] count;
  } track_result_t;

  // Track mirror and the queue of results it predicts.
  class track_scoreboard;
    logic [31:0]   key_times [TABLE_DEPTH];
    lanes_t        key_lanes [TABLE_DEPTH];
    logic [1:0]    key_modes [TABLE_DEPTH];
    logic [2:0]    key_kinds [TABLE_DEPTH];
    int            held;
    track_result_t pending[$];
    int            errors;

    function new();
      held = 0;
      errors = 0;
    endfunction

    function automatic logic [1:0] put_key(logic [31:0] tm, logic [1:0] mode,
                                           logic [2:0] kind, lanes_t lanes);
      int pos;
      pos = held;
      if (held >= TABLE_DEPTH) return STAT_FULL;
      for (int i = 0; i < held; i++)
        if ($signed(tm) < $signed(key_times[i])) begin
          pos = i;
          break;
        end
      for (int i = held; i > pos; i--) begin
        key_times[i] = key_times[i-1];
        key_lanes[i] = key_lanes[i-1];
        key_modes[i] = key_modes[i-1];
        key_kinds[i] = key_kinds[i-1];
      end
      key_times[pos] = tm;
      key_lanes[pos] = lanes;
      key_modes[pos] = mode;
      key_kinds[pos] = kind;
      held++;
      return STAT_OK;
    endfunction

    function automatic lanes_t live_lanes(int k);
      lanes_t r;
      r = '0;
      case (key_kinds[k])
        KIND_REAL, KIND_INTEGER, KIND_BOOL: r[0] = key_lanes[k][0];
        KIND_VEC2: for (int j = 0; j < 2; j++) r[j] = key_lanes[k][j];
        KIND_VEC3: for (int j = 0; j < 3; j++) r[j] = key_lanes[k][j];
        KIND_COLOUR: r = key_lanes[k];
        default: r = '0;
      endcase
      return r;
    endfunction

    function automatic track_result_t sample_track(logic [31:0] qt);
      track_result_t res;
      longint q, num, den, frac, a, b, p, sh;
      int lo, hi, mid, nl;
      res = '{STAT_OK, KIND_REAL, '0, 0};
      q = $signed(qt);
      if (held == 0) begin
        res.status = STAT_EMPTY;
        return res;
      end
      if (held == 1 || q <= longint'($signed(key_times[0]))) begin
        res.kind = key_kinds[0];
        res.lanes = live_lanes(0);
        return res;
      end
      if (q >= longint'($signed(key_times[held-1]))) begin
        res.kind = key_kinds[held-1];
        res.lanes = live_lanes(held-1);
        return res;
      end
      lo = 0;
      hi = held - 1;
      while (lo + 1 < hi) begin
        mid = (lo + hi) / 2;
        if (longint'($signed(key_times[mid])) <= q) lo = mid;
        else hi = mid;
      end
      res.kind = key_kinds[lo];
      res.lanes = live_lanes(lo);
      if (key_modes[lo] == MODE_STEP) return res;
      case (res.kind)
        KIND_REAL: nl = 1;
        KIND_VEC2: nl = 2;
        KIND_VEC3: nl = 3;
        KIND_COLOUR: nl = 4;
        default: return res;
      endcase
      num = q - longint'($signed(key_times[lo]));
      den = longint'($signed(key_times[hi])) - longint'($signed(key_times[lo]));
      if (num <= 0 || den < 0) frac = 0;
      else if (den == 0 || num >= den) frac = 65536;
      else frac = (num * 65536) / den;
      for (int j = 0; j < nl; j++) begin
        a = $signed(key_lanes[lo][j]);
        b = $signed(key_lanes[hi][j]);
        p = (b - a) * frac;
        sh = (p >= 0) ? (p >>> 16) : -((-p + 65535) >>> 16);
        res.lanes[j] = 32'(a + sh);
      end
      return res;
    endfunction

    // Apply an accepted request to the mirror and queue its result.
    function void note_request(track_req_t r);
      track_result_t res;
      lanes_t v;
      logic [2:0] dk;
      res = '{STAT_OK, KIND_REAL, '0, 0};
      case (r.op)
        OP_INSERT: begin
          v = r.lanes;
          if (r.kind == KIND_BOOL) v[0] = (v[0] != 0) ? 32'd1 : 32'd0;
          res.status = put_key(r.tm, r.mode, r.kind, v);
        end
        OP_INSERT_DEF: begin
          dk = KIND_REAL;
          if (held > 0 && key_kinds[0] <= KIND_COLOUR) dk = key_kinds[0];
          v = (dk == KIND_COLOUR) ? {4{ONE_Q16}} : '0;
          res.status = put_key(r.tm, MODE_LINEAR, dk, v);
        end
        OP_SET_TIME: begin
          if (r.idx < held) key_times[r.idx] = r.tm;
          else res.status = STAT_BAD_INDEX;
        end
        OP_REMOVE: begin
          if (r.idx < held) begin
            for (int i = r.idx; i + 1 < held; i++) begin
              key_times[i] = key_times[i+1];
              key_lanes[i] = key_lanes[i+1];
              key_modes[i] = key_modes[i+1];
              key_kinds[i] = key_kinds[i+1];
            end
            held--;
          end else res.status = STAT_BAD_INDEX;
        end
        OP_EVAL: res = sample_track(r.tm);
        default: ;
      endcase
      res.count = 7'(held);
      pending.insert(pending.size(), res);
    endfunction

    function void check_result(track_result_t got);
      track_result_t exp_res;
      if (pending.size() == 0) begin
        $error("result strobe with no request outstanding");
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (got.status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, got.status);
        errors++;
      end
      if (got.kind !== exp_res.kind) begin
        $error("result_kind: expected %0d, got %0d", exp_res.kind, got.kind);
        errors++;
      end
      for (int j = 0; j < 4; j++)
        if (got.lanes[j] !== exp_res.lanes[j]) begin
          $error("out_lane[%0d]: expected %h, got %h", j, exp_res.lanes[j], got.lanes[j]);
          errors++;
        end
      if (got.count !== exp_res.count) begin
        $error("key_count: expected %0d, got %0d", exp_res.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  operation = '0;
  logic [31:0] key_time = '0;
  logic [5:0]  key_index = '0;
  logic [1:0]  interp_mode = '0;
  logic [2:0]  value_kind = '0;
  logic [31:0] lane_zero = '0, lane_one = '0, lane_two = '0, lane_three = '0;
  logic        done;
  logic [1:0]  status;
  logic [2:0]  result_kind;
  logic [31:0] out_lane_zero, out_lane_one, out_lane_two, out_lane_three;
  logic [6:0]  key_count;

  track_scoreboard board = new();
  int idle_pct = 0;   // percentage of gaps the sender inserts between requests
  int quiet_cycles = 0;

  keyframe_track_evaluator_core uut (
    .clk, .rst, .start, .busy, .operation, .key_time, .key_index, .interp_mode,
    .value_kind, .lane_zero, .lane_one, .lane_two, .lane_three, .done, .status,
    .result_kind, .out_lane_zero, .out_lane_one, .out_lane_two, .out_lane_three,
    .key_count
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results are checked at the rising edge; the watchdog counts cycles without
  // any request or result being taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        board.check_result('{status, result_kind,
                             {out_lane_three, out_lane_two, out_lane_one, out_lane_zero},
                             key_count});
      if (done || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Drive one request on the falling edge, hold until taken at a rising edge.
  // start stays high on return; the next request or wait_drained sets it.
  task automatic send_request(track_req_t r);
    bit taken;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    start <= 1'b1;
    operation <= r.op;
    key_time <= r.tm;
    key_index <= r.idx;
    interp_mode <= r.mode;
    value_kind <= r.kind;
    {lane_three, lane_two, lane_one, lane_zero} <= r.lanes;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      if (!busy) begin
        taken = 1;
        board.note_request(r);
      end
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  function automatic lanes_t rand_lanes();
    lanes_t v;
    for (int j = 0; j < 4; j++)
      case ($urandom_range(3))
        0: v[j] = $urandom();
        1: v[j] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: v[j] = 32'($signed($urandom_range(400000)) - 200000);
      endcase
    return v;
  endfunction

  // Times mostly cluster so that keys bracket queries; some are full range.
  function automatic logic [31:0] rand_time();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2, 3: return 32'($urandom_range(8)) << 16;
      default: return 32'($signed($urandom_range(1200000)) - 200000);
    endcase
  endfunction

  function automatic track_req_t rand_request();
    track_req_t r;
    int pick;
    r.tm = rand_time();
    r.mode = 2'($urandom_range(3));
    r.kind = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
    r.lanes = rand_lanes();
    // Index mostly valid, now and then any 6-bit value, which may fall past the end.
    if ($urandom_range(7) == 0 || board.held == 0) r.idx = 6'($urandom());
    else r.idx = 6'($urandom_range(board.held - 1));
    pick = $urandom_range(99);
    // Keep the table mostly a handful of keys, grow or shrink as it drifts.
    if (pick < 30) r.op = (board.held > 12 && $urandom_range(1)) ? OP_REMOVE : OP_INSERT;
    else if (pick < 37) r.op = OP_INSERT_DEF;
    else if (pick < 43) r.op = OP_SET_TIME;
    else if (pick < 55) r.op = OP_REMOVE;
    else if (pick < 98) r.op = OP_EVAL;
    else r.op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    return r;
  endfunction

  function automatic track_req_t make_req(logic [2:0] op, logic [31:0] tm, logic [5:0] idx,
                                          logic [1:0] mode, logic [2:0] kind, lanes_t v);
    track_req_t r;
    r = '{op, tm, idx, mode, kind, v};
    return r;
  endfunction

  initial begin
    track_req_t r;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, bad indices, every kind and mode, extremes.
    send_request(make_req(OP_EVAL, 32'h0, 6'd0, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_REMOVE, 32'h0, 6'd0, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_SET_TIME, 32'h0, 6'd63, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_INSERT_DEF, 32'h0001_0000, 6'd0, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_INSERT, 32'h8000_0000, 6'd0, MODE_CUBIC, KIND_COLOUR,
                          {32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0}));
    send_request(make_req(OP_INSERT_DEF, 32'h0003_0000, 6'd0, MODE_STEP, KIND_BOOL, '1));
    send_request(make_req(OP_INSERT, 32'h7FFF_FFFF, 6'd0, MODE_SPARE, KIND_COLOUR,
                          {32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF}));
    send_request(make_req(OP_EVAL, 32'h8000_0000, 6'd0, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_EVAL, 32'h7FFF_FFFF, 6'd0, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_EVAL, 32'h0, 6'd0, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_EVAL, 32'h4000_0000, 6'd0, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_INSERT, 32'h0002_0000, 6'd0, MODE_STEP, KIND_VEC3, rand_lanes()));
    send_request(make_req(OP_INSERT, 32'h0002_0000, 6'd0, MODE_LINEAR, KIND_BOOL, '1));
    send_request(make_req(OP_INSERT, 32'h0002_8000, 6'd0, MODE_LINEAR, KIND_INTEGER, '1));
    send_request(make_req(OP_INSERT, 32'h0002_C000, 6'd0, MODE_LINEAR, KIND_VEC2, rand_lanes()));
    send_request(make_req(OP_INSERT, 32'h0002_E000, 6'd0, MODE_LINEAR, KIND_SPARE6, '1));
    send_request(make_req(OP_EVAL, 32'h0002_4000, 6'd0, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_EVAL, 32'h0002_D000, 6'd0, MODE_LINEAR, KIND_REAL, '0));
    // Break the order, then query across the unsorted span.
    send_request(make_req(OP_SET_TIME, 32'hFFFF_0000, 6'd3, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_EVAL, 32'h0001_8000, 6'd0, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_INSERT, 32'h8000_0000, 6'd0, MODE_LINEAR, KIND_SPARE7, '1));
    send_request(make_req(OP_INSERT_DEF, 32'h0, 6'd0, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_REMOVE, 32'h0, 6'd0, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_SPARE_LO, 32'h0, 6'd0, MODE_LINEAR, KIND_REAL, '0));
    // Fill to capacity and push one past it.
    while (board.held < TABLE_DEPTH)
      send_request(make_req(OP_INSERT_DEF, rand_time(), 6'd0, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_INSERT, 32'h0, 6'd0, MODE_LINEAR, KIND_REAL, '1));
    send_request(make_req(OP_INSERT_DEF, 32'h0, 6'd0, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_EVAL, rand_time(), 6'd0, MODE_LINEAR, KIND_REAL, '0));
    send_request(make_req(OP_REMOVE, 32'h0, 6'd63, MODE_LINEAR, KIND_REAL, '0));
    while (board.held > 3)
      send_request(make_req(OP_REMOVE, 32'h0, 6'($urandom_range(board.held - 1)),
                            MODE_LINEAR, KIND_REAL, '0));

    // Hold the sender off until the block has answered everything.
    wait_drained();

    // Random: three phases of sender pacing.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 23 : (phase == 1) ? 77 : 0;
      for (int n = 0; n < 180; n++) begin
        r = rand_request();
        send_request(r);
      end
      wait_drained();
    end

    wait_drained();
    repeat (200) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
